// File: hdl/rrb_pkg.sv
package rrb_pkg;

    localparam int COORD_W    = 10;
    localparam int PIXEL_W    = 32;
    localparam int RECT_W     = 13;
    localparam int COLOR_W    = 24;
    localparam int ALPHA_W    = 8;
    localparam int POS_FLD_W  = 15;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int GEOM_W     = 15;
    localparam int RSQ_W      = 26;
    localparam int CHAN_W     = 8;
    localparam int POS_W      = 5;
    localparam int MIX_W      = 16;
    localparam int NUM_CHAN   = 3;

    localparam int SURFACE_WIDTH_DEF  = 1024;
    localparam int SURFACE_HEIGHT_DEF = 1024;

    localparam logic [CHAN_W-1:0]    CHAN_MAX    = 8'hFF;
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET = 8'd255;
    localparam logic [POS_FLD_W-1:0] POS_RESET   = 15'd16640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_LEFT   = 3'd0,
        CFG_RECT_TOP    = 3'd1,
        CFG_RECT_RIGHT  = 3'd2,
        CFG_RECT_BOTTOM = 3'd3,
        CFG_RADIUS      = 3'd4,
        CFG_FILL_COLOR  = 3'd5,
        CFG_ALPHA       = 3'd6,
        CFG_POSITIONS   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [PIXEL_W-1:0] old_pixel;
    } t_pix_in;

    typedef struct packed {
        logic               write_pixel;
        logic [PIXEL_W-1:0] new_pixel;
    } t_pix_out;

    // clamped rectangle, inner corner edges and squared radius
    typedef struct packed {
        logic [GEOM_W-1:0] x0;
        logic [GEOM_W-1:0] y0;
        logic [GEOM_W-1:0] x1;
        logic [GEOM_W-1:0] y1;
        logic [GEOM_W-1:0] xl;
        logic [GEOM_W-1:0] xr;
        logic [GEOM_W-1:0] yt;
        logic [GEOM_W-1:0] yb;
        logic [RSQ_W-1:0]  rsq;
    } t_geom;

    typedef struct packed {
        logic [COLOR_W-1:0]   fill_color;
        logic [ALPHA_W-1:0]   alpha;
        logic [POS_FLD_W-1:0] positions;
    } t_blend_cfg;

endpackage

// File: hdl/rrb_cfg.sv
module rrb_cfg
    import rrb_pkg::*;
#(
    parameter int SURFACE_WIDTH  = SURFACE_WIDTH_DEF,
    parameter int SURFACE_HEIGHT = SURFACE_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_geom                 o_geom,
    output t_blend_cfg            o_blend
);

    localparam logic signed [GEOM_W-1:0] SW = GEOM_W'(SURFACE_WIDTH);
    localparam logic signed [GEOM_W-1:0] SH = GEOM_W'(SURFACE_HEIGHT);

    logic [RECT_W-1:0]    r_left, r_top, r_right, r_bottom, r_radius;
    logic [COLOR_W-1:0]   r_fill;
    logic [ALPHA_W-1:0]   r_alpha;
    logic [POS_FLD_W-1:0] r_pos;
    t_geom                r_geom;
    t_geom                n_geom;

    function automatic logic signed [GEOM_W-1:0] sx(input logic [RECT_W-1:0] v);
        return {{(GEOM_W-RECT_W){v[RECT_W-1]}}, v};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_radius <= '0;
            r_fill   <= '0;
            r_alpha  <= ALPHA_RESET;
            r_pos    <= POS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RECT_LEFT:   r_left   <= i_cfg_data[RECT_W-1:0];
                CFG_RECT_TOP:    r_top    <= i_cfg_data[RECT_W-1:0];
                CFG_RECT_RIGHT:  r_right  <= i_cfg_data[RECT_W-1:0];
                CFG_RECT_BOTTOM: r_bottom <= i_cfg_data[RECT_W-1:0];
                CFG_RADIUS:      r_radius <= i_cfg_data[RECT_W-1:0];
                CFG_FILL_COLOR:  r_fill   <= i_cfg_data[COLOR_W-1:0];
                CFG_ALPHA:       r_alpha  <= i_cfg_data[ALPHA_W-1:0];
                CFG_POSITIONS:   r_pos    <= i_cfg_data[POS_FLD_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [GEOM_W-1:0]   left_s, top_s, right_s, bottom_s, rad_s;
    logic signed [GEOM_W-1:0]   x0c, y0c, x1c, y1c, w, h, r0, r1, r2;
    logic signed [2*GEOM_W-1:0] rsq_full;

    always_comb begin
        left_s   = sx(r_left);
        top_s    = sx(r_top);
        right_s  = sx(r_right);
        bottom_s = sx(r_bottom);
        rad_s    = sx(r_radius);

        x0c = left_s[GEOM_W-1] ? '0 : left_s;
        y0c = top_s[GEOM_W-1]  ? '0 : top_s;
        x1c = (right_s > SW)  ? SW : right_s;
        y1c = (bottom_s > SH) ? SH : bottom_s;
        w   = x1c - x0c;
        h   = y1c - y0c;

        // radius clamp: width first, then height on the already clamped value
        r0 = rad_s[GEOM_W-1] ? '0 : rad_s;
        r1 = ((r0 <<< 1) > w) ? (w >>> 1) : r0;
        r2 = ((r1 <<< 1) > h) ? (h >>> 1) : r1;
        rsq_full = r2 * r2;

        n_geom.x0  = x0c;
        n_geom.y0  = y0c;
        n_geom.x1  = x1c;
        n_geom.y1  = y1c;
        n_geom.xl  = x0c + r2;
        n_geom.xr  = x1c - r2;
        n_geom.yt  = y0c + r2;
        n_geom.yb  = y1c - r2;
        n_geom.rsq = rsq_full[RSQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom <= '0;
        end else begin
            r_geom <= n_geom;
        end
    end

    assign o_geom             = r_geom;
    assign o_blend.fill_color = r_fill;
    assign o_blend.alpha      = r_alpha;
    assign o_blend.positions  = r_pos;

endmodule

// File: hdl/rrb_shape.sv
module rrb_shape
    import rrb_pkg::*;
(
    input  logic               i_clk,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    input  t_geom              i_geom,
    output logic               o_hit
);

    logic signed [GEOM_W-1:0] xs, ys, cx, cy;
    logic                     left, right, top, bot;
    logic                     n_in_range, n_corner;
    logic signed [GEOM_W-1:0] n_dx, n_dy;

    logic                     r_in_range, r_corner;
    logic signed [GEOM_W-1:0] r_dx, r_dy;

    assign xs = $signed({{(GEOM_W-COORD_W){1'b0}}, i_x});
    assign ys = $signed({{(GEOM_W-COORD_W){1'b0}}, i_y});

    always_comb begin
        n_in_range = (xs >= $signed(i_geom.x0)) && (xs < $signed(i_geom.x1)) &&
                     (ys >= $signed(i_geom.y0)) && (ys < $signed(i_geom.y1));
        left  = xs <  $signed(i_geom.xl);
        right = xs >= $signed(i_geom.xr);
        top   = ys <  $signed(i_geom.yt);
        bot   = ys >= $signed(i_geom.yb);
        n_corner = (left || right) && (top || bot);
        // left and top corners win when both sides match
        cx = left ? $signed(i_geom.xl) : $signed(i_geom.xr) - GEOM_W'(1);
        cy = top  ? $signed(i_geom.yt) : $signed(i_geom.yb) - GEOM_W'(1);
        n_dx = xs - cx;
        n_dy = ys - cy;
    end

    always_ff @(posedge i_clk) begin
        r_in_range <= n_in_range;
        r_corner   <= n_corner;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
    end

    logic signed [2*GEOM_W-1:0] sq_x, sq_y;
    logic signed [2*GEOM_W:0]   sq_sum, rsq_ext;

    assign sq_x    = r_dx * r_dx;
    assign sq_y    = r_dy * r_dy;
    assign sq_sum  = (2*GEOM_W+1)'(sq_x) + (2*GEOM_W+1)'(sq_y);
    assign rsq_ext = $signed({{(2*GEOM_W+1-RSQ_W){1'b0}}, i_geom.rsq});
    assign o_hit   = r_in_range && (!r_corner || (sq_sum <= rsq_ext));

endmodule

// File: hdl/rrb_blend.sv
module rrb_blend
    import rrb_pkg::*;
(
    input  logic               i_clk,
    input  logic [PIXEL_W-1:0] i_old,
    input  t_blend_cfg         i_cfg,
    output logic [PIXEL_W-1:0] o_word
);

    logic [POS_W-1:0]  pos  [NUM_CHAN];
    logic [CHAN_W-1:0] fill [NUM_CHAN];
    logic [MIX_W-1:0]  n_mix [NUM_CHAN];
    logic [MIX_W-1:0]  r_mix [NUM_CHAN];

    assign pos[0]  = i_cfg.positions[14:10];
    assign pos[1]  = i_cfg.positions[9:5];
    assign pos[2]  = i_cfg.positions[4:0];
    assign fill[0] = i_cfg.fill_color[23:16];
    assign fill[1] = i_cfg.fill_color[15:8];
    assign fill[2] = i_cfg.fill_color[7:0];

    always_comb begin
        logic [CHAN_W-1:0] chan;
        logic [CHAN_W-1:0] inv_a;
        inv_a = CHAN_MAX - i_cfg.alpha;
        for (int i = 0; i < NUM_CHAN; i++) begin
            chan     = CHAN_W'(i_old >> pos[i]);
            n_mix[i] = MIX_W'(chan) * MIX_W'(inv_a) + MIX_W'(fill[i]) * MIX_W'(i_cfg.alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            r_mix[i] <= n_mix[i];
        end
    end

    // divide by 255 as (v + 1 + (v >> 8)) >> 8, exact below 65535
    always_comb begin
        logic [MIX_W:0]    q_sum;
        logic [CHAN_W-1:0] q;
        o_word = '0;
        for (int i = 0; i < NUM_CHAN; i++) begin
            q_sum  = (MIX_W+1)'(r_mix[i]) + (MIX_W+1)'(1) + (MIX_W+1)'(r_mix[i] >> CHAN_W);
            q      = q_sum[CHAN_W +: CHAN_W];
            o_word = o_word | (PIXEL_W'(q) << pos[i]);
        end
    end

endmodule

// File: hdl/rounded_rect_blend_pixel_top.sv
// Rounded rectangle alpha fill, one pixel per clock. Pulse i_start with a
// pixel position and the word stored there; the block is never busy outside
// reset, so a pixel may follow every cycle. Once the start beat has passed
// r_v0, r_v1 and r_v2, o_done strobes for exactly one cycle with the result:
// write_pixel set and the blended word when the pixel falls inside the clamped rounded rectangle,
// otherwise write_pixel clear and the old word unchanged. The receiver cannot
// stall and must take each result beat in the cycle it appears. The pixel path is
// the input register, one stage after the edge compares and channel
// products, and the result register after the corner distance test and the
// divide by 255. Write configuration only with no pixel in flight.
module rounded_rect_blend_pixel_top
    import rrb_pkg::*;
#(
    parameter int SURFACE_WIDTH  = SURFACE_WIDTH_DEF,
    parameter int SURFACE_HEIGHT = SURFACE_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_pix_in               i_pixel,
    output logic                  o_done,
    output t_pix_out              o_pixel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_geom              geom;
    t_blend_cfg         blend_cfg;
    logic               hit;
    logic [PIXEL_W-1:0] blend_word;

    t_pix_in            r_in;
    logic               r_v0, r_v1, r_v2;
    logic [PIXEL_W-1:0] r_old1;
    t_pix_out           r_out;
    t_pix_out           n_out;

    assign o_busy = !i_rst_n;

    rrb_cfg #(
        .SURFACE_WIDTH  (SURFACE_WIDTH),
        .SURFACE_HEIGHT (SURFACE_HEIGHT)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom),
        .o_blend    (blend_cfg)
    );

    rrb_shape u_shape (
        .i_clk  (i_clk),
        .i_x    (r_in.pixel_x),
        .i_y    (r_in.pixel_y),
        .i_geom (geom),
        .o_hit  (hit)
    );

    rrb_blend u_blend (
        .i_clk  (i_clk),
        .i_old  (r_in.old_pixel),
        .i_cfg  (blend_cfg),
        .o_word (blend_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        n_out.write_pixel = hit;
        n_out.new_pixel   = hit ? blend_word : r_old1;
    end

    always_ff @(posedge i_clk) begin
        r_in   <= i_pixel;
        r_old1 <= r_in.old_pixel;
        r_out  <= n_out;
    end

    assign o_done  = r_v2;
    assign o_pixel = r_out;

endmodule

// File: hdl/rrb_checker.sv
module rrb_checker
    import rrb_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_start,
    input logic     o_busy,
    input t_pix_in  i_pixel,
    input logic     o_done,
    input t_pix_out o_pixel
);

    // every accepted beat comes out as a result beat on o_done
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##2 o_done)
        else $error("accepted pixel produced no result beat");

    // no result beat without a matching start beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 3))
        else $error("result beat without an accepted pixel");

    // a pixel that is not written passes through untouched
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_pixel.write_pixel) |-> (o_pixel.new_pixel == $past(i_pixel.old_pixel, 3)))
        else $error("skipped pixel did not pass the old word through");

endmodule

bind rounded_rect_blend_pixel_top rrb_checker u_rrb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_pixel (i_pixel),
    .o_done  (o_done),
    .o_pixel (o_pixel)
);
